/* hw/rtl/utf8d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared payload types and byte class constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned NeedW = 2;

  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] ContBits  = 8'h3f;
  localparam logic [ByteW-1:0] Lead2Mask = 8'he0;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hc0;
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1f;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hf0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'he0;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0f;

  localparam logic [UnitW-1:0] ReplacementUnit = 16'hfffd;

  localparam logic [NeedW-1:0] NeedNone = 2'd0;
  localparam logic [NeedW-1:0] NeedOne  = 2'd1;
  localparam logic [NeedW-1:0] NeedTwo  = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             chunk_end;
  } byte_word_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             bad_sequence;
  } unit_word_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

/* hw/rtl/utf8d_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for input bytes and decoded code units.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic                  valid;
  logic                  ready;
  utf8d_pkg::byte_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface utf8d_unit_if;
  logic                  valid;
  logic                  ready;
  utf8d_pkg::unit_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/utf8d_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Holds one accepted byte word until the decode step consumes it.
// ----------------------------------------------------------------------------
module utf8d_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  utf8d_pkg::byte_word_t in_data_i,
  output utf8d_pkg::hs_t        stage_o,
  input  logic                  take_i,
  output utf8d_pkg::byte_word_t stage_data_o
);

  logic                  valid_q, valid_d;
  utf8d_pkg::byte_word_t data_q;
  logic                  load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.ready = in_ready_o;
  assign stage_data_o  = data_q;

endmodule

/* hw/rtl/utf8d_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Updates the partial value and the count of pending continuation bytes.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [utf8d_pkg::ByteW-1:0] byte_i,
  output logic                       res_valid_o,
  output utf8d_pkg::unit_word_t      res_o
);

  logic [utf8d_pkg::NeedW-1:0] need_q, need_d;
  logic [utf8d_pkg::UnitW-1:0] partial_q, partial_d;
  logic                        is_cont;
  logic                        is_lead2;
  logic                        is_lead3;
  logic [utf8d_pkg::UnitW-1:0] shifted;

  assign is_cont  = (byte_i & utf8d_pkg::ContMask) == utf8d_pkg::ContTag;
  assign is_lead2 = (byte_i & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag;
  assign is_lead3 = (byte_i & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag;
  assign shifted  = {partial_q[utf8d_pkg::UnitW-7:0], byte_i[5:0] & utf8d_pkg::ContBits[5:0]};

  always_comb begin
    need_d            = need_q;
    partial_d         = partial_q;
    res_valid_o       = 1'b0;
    res_o.code_unit   = {{(utf8d_pkg::UnitW-utf8d_pkg::ByteW){1'b0}}, byte_i};
    res_o.bad_sequence = 1'b0;
    if (fire_i) begin
      if (need_q != utf8d_pkg::NeedNone) begin
        if (is_cont) begin
          partial_d       = shifted;
          need_d          = need_q - utf8d_pkg::NeedOne;
          res_o.code_unit = shifted;
          res_valid_o     = (need_q == utf8d_pkg::NeedOne);
        end else begin
          need_d             = utf8d_pkg::NeedNone;
          res_o.code_unit    = utf8d_pkg::ReplacementUnit;
          res_o.bad_sequence = 1'b1;
          res_valid_o        = 1'b1;
        end
      end else begin
        priority if (!byte_i[utf8d_pkg::ByteW-1]) begin
          res_valid_o = 1'b1;
        end else if (is_lead2) begin
          partial_d = {{(utf8d_pkg::UnitW-utf8d_pkg::ByteW){1'b0}},
                       byte_i & utf8d_pkg::Lead2Bits};
          need_d    = utf8d_pkg::NeedOne;
        end else if (is_lead3) begin
          partial_d = {{(utf8d_pkg::UnitW-utf8d_pkg::ByteW){1'b0}},
                       byte_i & utf8d_pkg::Lead3Bits};
          need_d    = utf8d_pkg::NeedTwo;
        end else begin
          need_d = utf8d_pkg::NeedNone;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= utf8d_pkg::NeedNone;
    end else begin
      need_q <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    partial_q <= partial_d;
  end

  a_need_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q != 2'd3)
    else $error("continuation count out of range");

  a_bad_only_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bad_sequence) |-> (need_q != utf8d_pkg::NeedNone))
    else $error("replacement emitted outside a sequence");

  a_bad_is_fffd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bad_sequence) |-> (res_o.code_unit == utf8d_pkg::ReplacementUnit))
    else $error("replacement unit has wrong value");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (need_q == utf8d_pkg::NeedNone))
    else $error("sequence still open after a result");

endmodule

/* hw/rtl/utf8d_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one decoded word until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8d_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  utf8d_pkg::unit_word_t push_data_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8d_pkg::unit_word_t out_data_o
);

  logic                  valid_q, valid_d;
  utf8d_pkg::unit_word_t data_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hw/rtl/utf8_stream_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Path: input register, combinational decode step, then the result register.
// Throughput: one byte word per cycle while the result register has space.
// Each byte word yields zero or one code unit word, in input order.
// Reset clears the stage valid flags and the pending byte count at once.
// The partial value register holds no reset; each opening lead byte loads it.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8d_byte_if.sink    in_i,
  utf8d_unit_if.source  out_o
);

  utf8d_pkg::hs_t        in_hs;
  utf8d_pkg::byte_word_t stage_data;
  utf8d_pkg::unit_word_t res;
  logic                  res_valid;
  logic                  space;
  logic                  fire;

  assign fire = in_hs.valid && space;

  utf8d_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .stage_o     (in_hs),
    .take_i      (fire),
    .stage_data_o(stage_data)
  );

  utf8d_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (stage_data.data_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  utf8d_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_data_o (out_o.data)
  );

endmodule

/* dv/utf8_stream_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte words through the valid/ready input and predicts each code unit
// word. Every accepted output word is checked, in order, against a queue of
// predicted units. The run covers directed cases and a long back-pressure
// stall, then random streams under several idle patterns on both channels.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;

  localparam int unsigned PhaseBytes   = 360;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxReports   = 10;

  logic clk_i;
  logic rst_ni;

  utf8d_byte_if byte_ch ();
  utf8d_unit_if unit_ch ();

  utf8_stream_decoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (unit_ch)
  );

  logic [utf8d_pkg::UnitW-1:0] pend_value;
  logic [utf8d_pkg::NeedW-1:0] pend_count;
  utf8d_pkg::unit_word_t       expected_units[$];

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned stall_cycles;
  int unsigned bytes_decoded;
  int unsigned error_count;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Predicts the unit word caused by one byte and advances the decode state.
  function automatic bit predict_unit(input logic [utf8d_pkg::ByteW-1:0] octet,
                                      output utf8d_pkg::unit_word_t unit,
                                      output bit dropped);
    unit.code_unit    = '0;
    unit.bad_sequence = 1'b0;
    dropped           = 1'b0;
    if (pend_count != utf8d_pkg::NeedNone) begin
      if ((octet & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
        pend_value = {pend_value[utf8d_pkg::UnitW-7:0], octet[5:0]};
        pend_count = pend_count - utf8d_pkg::NeedOne;
        if (pend_count == utf8d_pkg::NeedNone) begin
          unit.code_unit = pend_value;
          return 1'b1;
        end
        return 1'b0;
      end
      pend_count        = utf8d_pkg::NeedNone;
      unit.code_unit    = utf8d_pkg::ReplacementUnit;
      unit.bad_sequence = 1'b1;
      return 1'b1;
    end
    if (octet[utf8d_pkg::ByteW-1] == 1'b0) begin
      unit.code_unit = {8'h00, octet};
      return 1'b1;
    end
    if ((octet & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
      pend_value = {8'h00, octet & utf8d_pkg::Lead2Bits};
      pend_count = utf8d_pkg::NeedOne;
    end else if ((octet & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
      pend_value = {8'h00, octet & utf8d_pkg::Lead3Bits};
      pend_count = utf8d_pkg::NeedTwo;
    end else begin
      dropped = 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [utf8d_pkg::ByteW-1:0] octet, input logic last);
    utf8d_pkg::unit_word_t unit;
    bit                    dropped;
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data.data_byte <= octet;
    byte_ch.data.chunk_end <= last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    if (predict_unit(octet, unit, dropped)) expected_units.push_back(unit);
    if (!dropped) bytes_decoded++;
  endtask

  task automatic flag_error();
    error_count++;
  endtask

  // Output side: checks each accepted word, then picks the next ready value.
  always @(posedge clk_i) begin
    if (unit_ch.valid && unit_ch.ready) begin
      if (expected_units.size() == 0) begin
        if (error_count < MaxReports) begin
          $display("unexpected unit word: unit %h bad %b",
                   unit_ch.data.code_unit, unit_ch.data.bad_sequence);
        end
        flag_error();
      end else begin
        if (unit_ch.data.code_unit !== expected_units[0].code_unit ||
            unit_ch.data.bad_sequence !== expected_units[0].bad_sequence) begin
          if (error_count < MaxReports) begin
            $display("unit word mismatch: expected unit %h bad %b, got unit %h bad %b",
                     expected_units[0].code_unit, expected_units[0].bad_sequence,
                     unit_ch.data.code_unit, unit_ch.data.bad_sequence);
          end
          flag_error();
        end
        void'(expected_units.pop_front());
      end
    end
    if (stall_cycles > 0) begin
      stall_cycles = stall_cycles - 1;
      unit_ch.ready <= 1'b0;
    end else begin
      unit_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
  endtask

  task automatic test_two_byte();
    send_byte(8'hc0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hdf, 1'b1);
    send_byte(8'hbf, 1'b0);
  endtask

  task automatic test_three_byte();
    send_byte(8'he0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbf, 1'b1);
    send_byte(8'hbf, 1'b1);
  endtask

  task automatic test_broken_sequence();
    send_byte(8'hc3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'he4, 1'b0);
    send_byte(8'hb8, 1'b1);
    send_byte(8'he4, 1'b0);
  endtask

  task automatic test_dropped_bytes();
    send_byte(8'hbd, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hf0, 1'b0);
    send_byte(8'hf8, 1'b1);
    send_byte(8'hff, 1'b0);
  endtask

  // The output side holds off while the input keeps offering words, so the
  // pipeline fills and the input stalls.
  task automatic test_backpressure();
    int unsigned saved_idle;
    saved_idle   = src_idle_pct;
    src_idle_pct = 0;
    stall_cycles = 80;
    for (int i = 0; i < 48; i++) begin
      send_byte(8'h20 + i[7:0], 1'b0);
    end
    src_idle_pct = saved_idle;
  endtask

  task automatic send_random_sequence();
    int unsigned kind;
    logic        last;
    kind = $urandom_range(99);
    last = ($urandom_range(7) == 0);
    if (kind < 40) begin
      send_byte({1'b0, 7'($urandom_range(127))}, last);
    end else if (kind < 60) begin
      send_byte({3'b110, 5'($urandom_range(31))}, 1'b0);
      send_byte({2'b10, 6'($urandom_range(63))}, last);
    end else if (kind < 82) begin
      send_byte({4'b1110, 4'($urandom_range(15))}, 1'b0);
      send_byte({2'b10, 6'($urandom_range(63))}, $urandom_range(7) == 0);
      send_byte({2'b10, 6'($urandom_range(63))}, last);
    end else if (kind < 90) begin
      if ($urandom_range(1) == 0) begin
        send_byte({3'b110, 5'($urandom_range(31))}, 1'b0);
      end else begin
        send_byte({4'b1110, 4'($urandom_range(15))}, 1'b0);
        if ($urandom_range(1) == 0) send_byte({2'b10, 6'($urandom_range(63))}, 1'b0);
      end
      if ($urandom_range(1) == 0) begin
        send_byte({1'b0, 7'($urandom_range(127))}, last);
      end else begin
        send_byte({2'b11, 6'($urandom_range(63))}, last);
      end
    end else begin
      send_byte(8'($urandom_range(255)), last);
    end
  endtask

  task automatic test_random_stream(input int unsigned src_pct, input int unsigned dst_pct);
    int unsigned target;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    target       = bytes_decoded + PhaseBytes;
    while (bytes_decoded < target) send_random_sequence();
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (expected_units.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_units.size() != 0) begin
      $display("%0d predicted unit words never arrived", expected_units.size());
      error_count += expected_units.size();
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    byte_ch.valid          = 1'b0;
    byte_ch.data.data_byte = '0;
    byte_ch.data.chunk_end = 1'b0;
    unit_ch.ready          = 1'b0;
    pend_value             = '0;
    pend_count             = utf8d_pkg::NeedNone;
    src_idle_pct           = 28;
    dst_idle_pct           = 46;
    stall_cycles           = 0;
    bytes_decoded          = 0;
    error_count            = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii();
    test_two_byte();
    test_three_byte();
    test_broken_sequence();
    test_dropped_bytes();
    test_backpressure();
    test_random_stream(28, 46);
    test_random_stream(46, 28);
    test_random_stream(0, 0);

    byte_ch.valid <= 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_if.sv
hw/rtl/utf8d_in_stage.sv
hw/rtl/utf8d_step.sv
hw/rtl/utf8d_out_stage.sv
hw/rtl/utf8_stream_decoder_top.sv
dv/utf8_stream_decoder_top_tb.sv
